// File: sv/zrt_pkg.sv
`timescale 1ns / 1ps
// Package with shared types, constants and codes of the zone remap translator.
package zrt_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int MAX_ZONES    = 256;
  localparam int CH_W         = 4;
  localparam int ZONE_W       = 8;
  localparam int ADDR_W       = CH_W + ZONE_W;
  localparam int MAP_DEPTH    = NUM_CHANNELS * MAX_ZONES;
  localparam int PAGE_W       = 32;
  localparam int ZP_W         = 25;
  localparam int ZC_W         = 9;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 25;
  localparam int QDEPTH       = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_PAGES = 1'd1;

  typedef enum logic [1:0] {
    OP_TRANSLATE = 2'd0,
    OP_SWAP      = 2'd1,
    OP_QUERY     = 2'd2,
    OP_NOP       = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_BAD_CHANNEL    = 3'd1,
    ST_OUT_OF_RANGE   = 3'd2,
    ST_NOT_CONFIGURED = 3'd3,
    ST_INVALID_SWAP   = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [CH_W-1:0]   channel_index;
    logic [PAGE_W-1:0] chan_page;
    logic [ZONE_W-1:0] first_zone;
    logic [ZONE_W-1:0] second_zone;
  } in_item_t;

  typedef struct packed {
    logic [PAGE_W-1:0] physical_page;
    logic [ZONE_W-1:0] mapped_zone;
    logic [2:0]        status;
  } out_item_t;

  // Job handed from the front to the back.
  typedef enum logic [2:0] {
    JOB_DONE,      // result is final, no map work
    JOB_TRANSLATE, // divide then look up
    JOB_SWAP,
    JOB_QUERY,
    JOB_INIT       // map identity sweep marker (unused by front)
  } job_t;

  typedef struct packed {
    job_t              job;
    logic [CH_W-1:0]   channel_index;
    logic [PAGE_W-1:0] chan_page;
    logic [ZONE_W-1:0] first_zone;
    logic [ZONE_W-1:0] second_zone;
    out_item_t         result;
  } cmd_t;

  typedef enum logic [3:0] {
    BS_INIT, BS_IDLE, BS_DIV, BS_LOOK, BS_LOOKW, BS_MUL, BS_SWAPRD, BS_SWAPW1,
    BS_SWAPW2, BS_QRD, BS_QW, BS_OUT
  } bstate_t;

endpackage

// File: sv/zone_remap_translator.sv
`timescale 1ns / 1ps
// Top level of the zone remap translator.
// After reset the map is set to the identity by a sweep over all 4096 entries; items are still
// queued meanwhile but none is executed. A translate uses the radix-2 divider that does one
// quotient bit per cycle over 32 bits; swap and query are paced by the single map port. A
// two-entry queue sits between classification and execution.
module zone_remap_translator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  zrt_pkg::in_item_t                  in_item,
  output logic                               out_empty,
  input  logic                               out_pop,
  output zrt_pkg::out_item_t                 out_item,
  input  logic                               cfg_we,
  input  logic [zrt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [zrt_pkg::CFG_DATA_W-1:0]     cfg_data
);
  logic [zrt_pkg::ZC_W-1:0] zone_count_r;
  logic [zrt_pkg::ZP_W-1:0] zone_pages_r;
  logic                     cmd_valid, cmd_take;
  zrt_pkg::cmd_t            cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_count_r <= '0;
      zone_pages_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        zrt_pkg::CFG_ZONE_COUNT: zone_count_r <= cfg_data[zrt_pkg::ZC_W-1:0];
        zrt_pkg::CFG_ZONE_PAGES: zone_pages_r <= cfg_data[zrt_pkg::ZP_W-1:0];
        default: ;
      endcase
    end
  end

  zrt_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .zone_count(zone_count_r), .zone_pages(zone_pages_r),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd));

  zrt_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
    .zone_count(zone_count_r), .zone_pages(zone_pages_r),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item));
endmodule

// File: sv/zrt_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
module zrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: sv/zrt_front.sv
`timescale 1ns / 1ps
// Front end: accepts items, checks ranges and queues jobs for the back end.
module zrt_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  zrt_pkg::in_item_t            in_item,
  input  logic [zrt_pkg::ZC_W-1:0]     zone_count,
  input  logic [zrt_pkg::ZP_W-1:0]     zone_pages,
  output logic                         cmd_valid,
  input  logic                         cmd_take,
  output zrt_pkg::cmd_t                cmd
);
  zrt_pkg::cmd_t q_r [zrt_pkg::QDEPTH];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  zrt_pkg::cmd_t c;
  logic [zrt_pkg::ZC_W-1:0] lim;
  logic          push_ok;

  assign lim     = (zone_count > 9'(zrt_pkg::MAX_ZONES)) ? 9'(zrt_pkg::MAX_ZONES) : zone_count;
  assign in_full = (cnt_r == 2'(zrt_pkg::QDEPTH));
  assign push_ok = in_push && !in_full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd = q_r[rp_r];

  always_comb begin
    c.channel_index = in_item.channel_index;
    c.chan_page     = in_item.chan_page;
    c.first_zone    = in_item.first_zone;
    c.second_zone   = in_item.second_zone;
    c.result        = '0;
    c.job           = zrt_pkg::JOB_DONE;
    case (zrt_pkg::op_t'(in_item.operation))
      zrt_pkg::OP_TRANSLATE: begin
        if (zone_count == '0) begin
          c.result.physical_page = in_item.chan_page;
        end else if (zone_pages == '0) begin
          c.result.status = zrt_pkg::ST_NOT_CONFIGURED;
        end else begin
          c.job = zrt_pkg::JOB_TRANSLATE;
        end
      end
      zrt_pkg::OP_SWAP: begin
        if (zone_count == '0) begin
          c.result.status = zrt_pkg::ST_NOT_CONFIGURED;
        end else if ({1'b0, in_item.first_zone} >= lim || {1'b0, in_item.second_zone} >= lim
                     || in_item.first_zone == in_item.second_zone) begin
          c.result.status = zrt_pkg::ST_INVALID_SWAP;
        end else begin
          c.job = zrt_pkg::JOB_SWAP;
        end
      end
      zrt_pkg::OP_QUERY: begin
        if (zone_count == '0) begin
          c.result.status = zrt_pkg::ST_NOT_CONFIGURED;
        end else if ({1'b0, in_item.first_zone} >= lim) begin
          c.result.status = zrt_pkg::ST_OUT_OF_RANGE;
        end else begin
          c.job = zrt_pkg::JOB_QUERY;
        end
      end
      default: c.job = zrt_pkg::JOB_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wp_r] <= c;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok) begin
        wp_r <= ~wp_r;
      end
      if (cmd_take) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push_ok) - 2'(cmd_take);
    end
  end

`ifndef SYNTHESIS
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> cmd_valid) else $error("job taken from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(zrt_pkg::QDEPTH)) else $error("job queue count out of range");
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_full && !cmd_take) |=> in_full) else $error("queue lost a job");
`endif
endmodule

// File: sv/zrt_back.sv
`timescale 1ns / 1ps
// Back end: map identity sweep, divider, map access and one-entry result register.
module zrt_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cmd_valid,
  output logic                     cmd_take,
  input  zrt_pkg::cmd_t            cmd,
  input  logic [zrt_pkg::ZC_W-1:0] zone_count,
  input  logic [zrt_pkg::ZP_W-1:0] zone_pages,
  output logic                     out_empty,
  input  logic                     out_pop,
  output zrt_pkg::out_item_t       out_item
);
  zrt_pkg::bstate_t st_r, st_nxt;
  zrt_pkg::cmd_t    c_r;
  logic [zrt_pkg::PAGE_W-1:0] quo_r;
  logic [zrt_pkg::ZP_W-1:0]   rem_r;
  logic [5:0]                 bit_r;
  logic [zrt_pkg::ADDR_W-1:0] init_r;
  logic [zrt_pkg::ZONE_W-1:0] za_val_r;
  logic [40:0]                prod_r;
  zrt_pkg::out_item_t         res_r;
  logic                       full_r;
  logic [zrt_pkg::ZC_W-1:0]   lim;

  logic                       we;
  logic [zrt_pkg::ADDR_W-1:0] addr;
  logic [zrt_pkg::ZONE_W-1:0] wdata, rdata;
  logic [zrt_pkg::ZP_W:0]     trial;

  zrt_ram #(.WIDTH(zrt_pkg::ZONE_W), .DEPTH(zrt_pkg::MAP_DEPTH)) u_map (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

  assign lim   = (zone_count > 9'(zrt_pkg::MAX_ZONES)) ? 9'(zrt_pkg::MAX_ZONES) : zone_count;
  assign trial = {rem_r, quo_r[31]} - {1'b0, zone_pages};
  assign out_empty = !full_r;
  assign out_item  = res_r;
  assign cmd_take  = (st_r == zrt_pkg::BS_IDLE) && cmd_valid;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      zrt_pkg::BS_INIT:   if (init_r == '1) st_nxt = zrt_pkg::BS_IDLE;
      zrt_pkg::BS_IDLE:   if (cmd_valid) begin
        case (cmd.job)
          zrt_pkg::JOB_TRANSLATE: st_nxt = zrt_pkg::BS_DIV;
          zrt_pkg::JOB_SWAP:      st_nxt = zrt_pkg::BS_SWAPRD;
          zrt_pkg::JOB_QUERY:     st_nxt = zrt_pkg::BS_QRD;
          default:                st_nxt = zrt_pkg::BS_OUT;
        endcase
      end
      zrt_pkg::BS_DIV:    if (bit_r == 6'd31) st_nxt = zrt_pkg::BS_LOOK;
      zrt_pkg::BS_LOOK:   st_nxt = (quo_r >= 32'(lim)) ? zrt_pkg::BS_OUT : zrt_pkg::BS_LOOKW;
      zrt_pkg::BS_LOOKW:  st_nxt = zrt_pkg::BS_MUL;
      zrt_pkg::BS_MUL:    st_nxt = zrt_pkg::BS_OUT;
      zrt_pkg::BS_SWAPRD: st_nxt = zrt_pkg::BS_SWAPW1;
      zrt_pkg::BS_SWAPW1: st_nxt = zrt_pkg::BS_SWAPW2;
      zrt_pkg::BS_SWAPW2: st_nxt = zrt_pkg::BS_OUT;
      zrt_pkg::BS_QRD:    st_nxt = zrt_pkg::BS_QW;
      zrt_pkg::BS_QW:     st_nxt = zrt_pkg::BS_OUT;
      zrt_pkg::BS_OUT:    if (!full_r || out_pop) st_nxt = zrt_pkg::BS_IDLE;
      default:            st_nxt = zrt_pkg::BS_IDLE;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    wdata = za_val_r;
    addr  = {c_r.channel_index, c_r.first_zone};
    case (st_r)
      zrt_pkg::BS_INIT: begin
        we    = 1'b1;
        addr  = init_r;
        wdata = init_r[zrt_pkg::ZONE_W-1:0];
      end
      // The first zone's entry of the waiting job is read while it is taken.
      zrt_pkg::BS_IDLE:   addr = {cmd.channel_index, cmd.first_zone};
      zrt_pkg::BS_LOOK:   addr = {c_r.channel_index, quo_r[zrt_pkg::ZONE_W-1:0]};
      zrt_pkg::BS_SWAPRD: addr = {c_r.channel_index, c_r.second_zone};
      zrt_pkg::BS_SWAPW1: begin
        // First zone's entry was captured in za_val_r in BS_SWAPRD; second's is on rdata now.
        we    = 1'b1;
        wdata = rdata;
      end
      zrt_pkg::BS_SWAPW2: begin
        we   = 1'b1;
        addr = {c_r.channel_index, c_r.second_zone};
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      c_r   <= cmd;
      quo_r <= cmd.chan_page;
      rem_r <= '0;
      bit_r <= '0;
    end
    case (st_r)
      zrt_pkg::BS_DIV: begin
        bit_r <= bit_r + 6'd1;
        if (!trial[zrt_pkg::ZP_W]) begin
          rem_r <= trial[zrt_pkg::ZP_W-1:0];
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= {rem_r[zrt_pkg::ZP_W-2:0], quo_r[31]};
          quo_r <= {quo_r[30:0], 1'b0};
        end
      end
      zrt_pkg::BS_LOOK: begin
        if (quo_r >= 32'(lim)) begin
          c_r.result.status <= zrt_pkg::ST_OUT_OF_RANGE;
        end
      end
      zrt_pkg::BS_LOOKW: prod_r <= 41'(rdata * zone_pages);
      zrt_pkg::BS_MUL: begin
        if (prod_r + 41'(rem_r) > 41'hFFFF_FFFF) begin
          c_r.result.status <= zrt_pkg::ST_OUT_OF_RANGE;
        end else begin
          c_r.result.physical_page <= 32'(prod_r + 41'(rem_r));
        end
      end
      zrt_pkg::BS_SWAPRD: za_val_r <= rdata;
      zrt_pkg::BS_QW:     c_r.result.mapped_zone <= rdata;
      default: ;
    endcase
    if (st_r == zrt_pkg::BS_OUT && (!full_r || out_pop)) begin
      res_r <= c_r.result;
    end
    if (!rst_n) begin
      st_r   <= zrt_pkg::BS_INIT;
      init_r <= '0;
      full_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == zrt_pkg::BS_INIT) begin
        init_r <= init_r + zrt_pkg::ADDR_W'(1);
      end
      if (st_r == zrt_pkg::BS_OUT && (!full_r || out_pop)) begin
        full_r <= 1'b1;
      end else if (out_pop) begin
        full_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> st_r == zrt_pkg::BS_IDLE) else $error("job taken while busy");
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == zrt_pkg::BS_DIV) |-> bit_r < 6'd32) else $error("divider overran");
  a_swap_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == zrt_pkg::BS_SWAPW1) |=> st_r == zrt_pkg::BS_SWAPW2) else $error("swap broken");
`endif
endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the zone remap translator with a map-tracking scoreboard.
module testbench;

  localparam int CYCLE_LIMIT = 600000;

  // Tracks the zone map and register values, and holds the results still to arrive.
  class zone_map_scoreboard;
    bit [zrt_pkg::ZONE_W-1:0] zmap [zrt_pkg::NUM_CHANNELS][zrt_pkg::MAX_ZONES];
    bit [zrt_pkg::ZC_W-1:0] zcount;
    bit [zrt_pkg::ZP_W-1:0] zpages;
    zrt_pkg::out_item_t pending[$];
    int mismatches;
    int checked;
    int op_seen [4];
    int status_seen [8];

    function new();
      for (int c = 0; c < zrt_pkg::NUM_CHANNELS; c++)
        for (int z = 0; z < zrt_pkg::MAX_ZONES; z++)
          zmap[c][z] = z[zrt_pkg::ZONE_W-1:0];
    endfunction

    function void set_regs(bit [zrt_pkg::ZC_W-1:0] count, bit [zrt_pkg::ZP_W-1:0] pages);
      zcount = count;
      zpages = pages;
    endfunction

    function int zone_limit();
      return (zcount < zrt_pkg::MAX_ZONES) ? int'(zcount) : zrt_pkg::MAX_ZONES;
    endfunction

    // Works out the result of one accepted item and applies any map change.
    // The channel field is four bits wide, so a bad channel cannot occur.
    function void note_input(zrt_pkg::in_item_t it);
      zrt_pkg::out_item_t e;
      int lim;
      longint unsigned logical, offset, r;
      bit [zrt_pkg::ZONE_W-1:0] t;
      e = '0;
      lim = zone_limit();
      case (zrt_pkg::op_t'(it.operation))
        zrt_pkg::OP_TRANSLATE: begin
          if (zcount == 0) begin
            e.physical_page = it.chan_page;
          end else if (zpages == 0) begin
            e.status = zrt_pkg::ST_NOT_CONFIGURED;
          end else begin
            logical = longint'(it.chan_page) / longint'(zpages);
            offset = longint'(it.chan_page) % longint'(zpages);
            if (logical >= lim) begin
              e.status = zrt_pkg::ST_OUT_OF_RANGE;
            end else begin
              r = longint'(zmap[it.channel_index][logical]) * longint'(zpages) + offset;
              if (r > 64'hFFFF_FFFF) e.status = zrt_pkg::ST_OUT_OF_RANGE;
              else e.physical_page = r[31:0];
            end
          end
        end
        zrt_pkg::OP_SWAP: begin
          if (zcount == 0) begin
            e.status = zrt_pkg::ST_NOT_CONFIGURED;
          end else if (it.first_zone >= lim || it.second_zone >= lim ||
                       it.first_zone == it.second_zone) begin
            e.status = zrt_pkg::ST_INVALID_SWAP;
          end else begin
            t = zmap[it.channel_index][it.first_zone];
            zmap[it.channel_index][it.first_zone] = zmap[it.channel_index][it.second_zone];
            zmap[it.channel_index][it.second_zone] = t;
          end
        end
        zrt_pkg::OP_QUERY: begin
          if (zcount == 0) e.status = zrt_pkg::ST_NOT_CONFIGURED;
          else if (it.first_zone >= lim) e.status = zrt_pkg::ST_OUT_OF_RANGE;
          else e.mapped_zone = zmap[it.channel_index][it.first_zone];
        end
        default: ;
      endcase
      op_seen[it.operation]++;
      status_seen[e.status]++;
      pending.push_back(e);
    endfunction

    function void check_result(zrt_pkg::out_item_t got);
      zrt_pkg::out_item_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result with nothing expected: page %h zone %h status %0d",
                   got.physical_page, got.mapped_zone, got.status);
        return;
      end
      e = pending.pop_front();
      if (got.physical_page !== e.physical_page || got.mapped_zone !== e.mapped_zone ||
          got.status !== e.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d: expected page %h zone %h status %0d, got %h %h %0d",
                   checked, e.physical_page, e.mapped_zone, e.status,
                   got.physical_page, got.mapped_zone, got.status);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  zrt_pkg::in_item_t in_item;
  logic out_empty;
  logic out_pop;
  zrt_pkg::out_item_t out_item;
  logic cfg_we;
  logic [zrt_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [zrt_pkg::CFG_DATA_W-1:0] cfg_data;

  zone_map_scoreboard sb;
  bit calm;
  int cycles;

  zone_remap_translator dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    out_pop = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // The receiver stalls now and then; during the calm phase it never does.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) sb.check_result(out_item);
    out_pop <= calm || ($urandom_range(99) >= 8);
  end

  task automatic send_item(zrt_pkg::in_item_t it);
    while (!calm && $urandom_range(99) < 8) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_full);
    sb.note_input(it);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_regs(bit [zrt_pkg::ZC_W-1:0] count, bit [zrt_pkg::ZP_W-1:0] pages);
    cfg_we <= 1'b1;
    cfg_index <= zrt_pkg::CFG_ZONE_COUNT;
    cfg_data <= zrt_pkg::CFG_DATA_W'(count);
    @(posedge clk);
    cfg_index <= zrt_pkg::CFG_ZONE_PAGES;
    cfg_data <= pages;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_regs(count, pages);
  endtask

  function automatic zrt_pkg::in_item_t mk(zrt_pkg::op_t op, int ch, bit [31:0] page,
                                           int za, int zb);
    zrt_pkg::in_item_t it;
    it.operation = op;
    it.channel_index = ch[zrt_pkg::CH_W-1:0];
    it.chan_page = page;
    it.first_zone = za[zrt_pkg::ZONE_W-1:0];
    it.second_zone = zb[zrt_pkg::ZONE_W-1:0];
    return it;
  endfunction

  // Mostly well-formed items: zones within the limit and pages that land in a mapped zone.
  function automatic zrt_pkg::in_item_t random_item();
    zrt_pkg::in_item_t it;
    int lim, pick;
    longint unsigned zp, pg;
    lim = sb.zone_limit();
    zp = sb.zpages;
    pick = $urandom_range(99);
    it.operation = (pick < 45) ? zrt_pkg::OP_TRANSLATE : (pick < 70) ? zrt_pkg::OP_SWAP :
                   (pick < 92) ? zrt_pkg::OP_QUERY : zrt_pkg::OP_NOP;
    it.channel_index = 4'($urandom_range(zrt_pkg::NUM_CHANNELS - 1));
    it.first_zone = 8'((lim > 0 && $urandom_range(99) < 85) ? $urandom_range(lim - 1)
                                                              : $urandom);
    it.second_zone = 8'((lim > 0 && $urandom_range(99) < 85) ? $urandom_range(lim - 1)
                                                               : $urandom);
    if (zp != 0 && lim > 0 && $urandom_range(99) < 80) begin
      pg = longint'($urandom_range(lim - 1)) * zp + longint'($urandom_range(int'(zp - 1)));
      it.chan_page = pg[31:0];
    end else begin
      it.chan_page = $urandom;
    end
    return it;
  endfunction

  initial begin
    bit [zrt_pkg::ZC_W-1:0] counts [6];
    bit [zrt_pkg::ZP_W-1:0] sizes [6];
    sb = new();
    calm = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // Disabled: translate passes through, swap and query report not configured.
    write_regs(0, 0);
    send_item(mk(zrt_pkg::OP_TRANSLATE, 15, 32'hFFFF_FFFF, 0, 0));
    send_item(mk(zrt_pkg::OP_TRANSLATE, 0, 32'h0, 255, 255));
    send_item(mk(zrt_pkg::OP_SWAP, 0, 0, 0, 1));
    send_item(mk(zrt_pkg::OP_QUERY, 3, 0, 255, 0));
    send_item(mk(zrt_pkg::OP_NOP, 15, 32'hFFFF_FFFF, 255, 255));
    drain();

    // Enabled with zero zone size, then bounds and equal-zone swaps.
    write_regs(4, 0);
    send_item(mk(zrt_pkg::OP_TRANSLATE, 1, 7, 0, 0));
    send_item(mk(zrt_pkg::OP_QUERY, 1, 0, 3, 0));
    send_item(mk(zrt_pkg::OP_QUERY, 1, 0, 4, 0));
    send_item(mk(zrt_pkg::OP_SWAP, 1, 0, 3, 3));
    send_item(mk(zrt_pkg::OP_SWAP, 1, 0, 0, 4));
    send_item(mk(zrt_pkg::OP_SWAP, 1, 0, 0, 3));
    send_item(mk(zrt_pkg::OP_QUERY, 1, 0, 0, 0));
    drain();

    // Largest zones: zone 0 swapped with 255; pages reach the top of the 32-bit range, no overflow.
    write_regs(256, 25'd16777216);
    send_item(mk(zrt_pkg::OP_SWAP, 0, 0, 0, 255));
    send_item(mk(zrt_pkg::OP_TRANSLATE, 0, 5, 0, 0));
    send_item(mk(zrt_pkg::OP_TRANSLATE, 0, 32'hFFFF_FFFF, 0, 0));
    send_item(mk(zrt_pkg::OP_TRANSLATE, 2, 32'hFFFF_FFFF, 0, 0));
    send_item(mk(zrt_pkg::OP_QUERY, 0, 0, 255, 0));
    drain();

    // Smallest zones: one page each.
    write_regs(2, 1);
    send_item(mk(zrt_pkg::OP_TRANSLATE, 5, 1, 0, 0));
    send_item(mk(zrt_pkg::OP_TRANSLATE, 5, 2, 0, 0));
    send_item(mk(zrt_pkg::OP_SWAP, 5, 0, 0, 1));
    send_item(mk(zrt_pkg::OP_SWAP, 5, 0, 1, 2));
    send_item(mk(zrt_pkg::OP_TRANSLATE, 5, 0, 0, 0));
    drain();

    counts = '{9'd16, 9'd256, 9'd0, 9'd1, 9'h1FF, 9'd200};
    sizes = '{25'd1000, 25'd16777216, 25'd77, 25'd1, 25'h1FF_FFFF, 25'd0};
    for (int p = 0; p < 6; p++) begin
      write_regs(counts[p], (p == 5) ? 25'($urandom_range(65535)) : sizes[p]);
      calm = (p == 1);
      for (int i = 0; i < 240; i++) send_item(random_item());
      drain();
    end
    calm = 1'b0;

    // Zero zone size with remapping on.
    write_regs(32, 0);
    for (int i = 0; i < 20; i++) send_item(random_item());
    drain();

    $display("Checked %0d results: %0d translate, %0d swap, %0d query, %0d no-op items.",
             sb.checked, sb.op_seen[zrt_pkg::OP_TRANSLATE], sb.op_seen[zrt_pkg::OP_SWAP],
             sb.op_seen[zrt_pkg::OP_QUERY], sb.op_seen[zrt_pkg::OP_NOP]);
    $display("Statuses: ok %0d, out of range %0d, not configured %0d, invalid swap %0d.",
             sb.status_seen[zrt_pkg::ST_OK], sb.status_seen[zrt_pkg::ST_OUT_OF_RANGE],
             sb.status_seen[zrt_pkg::ST_NOT_CONFIGURED],
             sb.status_seen[zrt_pkg::ST_INVALID_SWAP]);
    if (sb.pending.size() != 0) begin
      sb.mismatches++;
      $display("ERROR: %0d results never arrived", sb.pending.size());
    end
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("FAILURE");
    end
    $finish;
  end
endmodule
